FILE: sv/assert_macros.svh
// assertion macros shared by the differential drive pose update block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent in any cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/ddpu_pkg.sv
// package with types, constants and tables of the differential drive pose update block
package ddpu_pkg;

   localparam int FRAC_BITS    = 8;
   localparam int MAX_ARENA    = 4096;
   localparam int CORDIC_STEPS = 16;

   localparam int POS_BITS    = 20;
   localparam int ANG_BITS    = 16;
   localparam int SPD_BITS    = 16;
   localparam int ARENA_BITS  = 13;
   localparam int GAIN_BITS   = 12;
   localparam int LIMIT_BITS  = 15;
   localparam int CSR_W       = 15;
   localparam int CSR_IDX_W   = 2;

   // clamped speeds and their sum or difference
   localparam int SUM_W   = SPD_BITS + 2;
   localparam int TRIG_W  = 32;
   localparam int PROD_W  = SUM_W + TRIG_W;
   localparam int DPROD_W = (SUM_W + GAIN_BITS + 1 > FRAC_BITS + ANG_BITS) ?
                            SUM_W + GAIN_BITS + 1 : FRAC_BITS + ANG_BITS;
   localparam int DX_W    = PROD_W - 31;

   localparam int CORDIC_W  = 34;
   localparam int ANG_SHIFT = 32 - ANG_BITS;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] QUARTER     = 34'sd1073741824;

   // arena reduction: binary steps from WRAP_TOP down to 0, then one final step
   localparam int WRAP_TOP = POS_BITS - FRAC_BITS;
   localparam int WRAP_W   = ARENA_BITS + FRAC_BITS + WRAP_TOP + 3;

   localparam int STEP_BITS = 5;
   localparam int RUN_LEN   = (CORDIC_STEPS > WRAP_TOP + 2) ? CORDIC_STEPS : WRAP_TOP + 2;
   localparam logic [STEP_BITS-1:0] CORDIC_END = STEP_BITS'(CORDIC_STEPS);
   localparam logic [STEP_BITS-1:0] WRAP_LAST  = STEP_BITS'(WRAP_TOP + 1);
   localparam logic [STEP_BITS-1:0] WRAP_TOPV  = STEP_BITS'(WRAP_TOP);
   localparam logic [STEP_BITS-1:0] RUN_LAST   = STEP_BITS'(RUN_LEN - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT  = 2'd3;

   localparam logic [ARENA_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [ARENA_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = 12'd209;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = 15'd2560;

   localparam logic action_tick = 1'b0;
   localparam logic action_load = 1'b1;

   typedef struct packed {
      logic                       action;
      logic signed [SPD_BITS-1:0] left_speed;
      logic signed [SPD_BITS-1:0] right_speed;
      logic signed [POS_BITS-1:0] new_x;
      logic signed [POS_BITS-1:0] new_y;
      logic signed [ANG_BITS-1:0] new_heading;
   } req_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0] x_position;
      logic signed [POS_BITS-1:0] y_position;
      logic signed [ANG_BITS-1:0] heading;
   } rsp_type;

   typedef struct packed {
      logic                 tick_start;
      logic                 load_start;
      logic                 cordic_en;
      logic                 wrap_en;
      logic [STEP_BITS-1:0] idx;
      logic                 mul;
      logic                 add;
      logic                 commit;
   } cmd_type;

   function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [STEP_BITS-1:0] i);
      logic signed [CORDIC_W-1:0] r;
      case (i)
         5'd0:  r = 34'sh020000000;
         5'd1:  r = 34'sh012E4051E;
         5'd2:  r = 34'sh009FB385B;
         5'd3:  r = 34'sh0051111D4;
         5'd4:  r = 34'sh0028B0D43;
         5'd5:  r = 34'sh00145D7E1;
         5'd6:  r = 34'sh000A2F61E;
         5'd7:  r = 34'sh000517C55;
         5'd8:  r = 34'sh00028BE53;
         5'd9:  r = 34'sh000145F2F;
         5'd10: r = 34'sh0000A2F98;
         5'd11: r = 34'sh0000517CC;
         5'd12: r = 34'sh000028BE6;
         5'd13: r = 34'sh0000145F3;
         5'd14: r = 34'sh00000A2FA;
         5'd15: r = 34'sh00000517D;
         5'd16: r = 34'sh0000028BE;
         5'd17: r = 34'sh00000145F;
         5'd18: r = 34'sh000000A30;
         5'd19: r = 34'sh000000518;
         5'd20: r = 34'sh00000028C;
         5'd21: r = 34'sh000000146;
         5'd22: r = 34'sh0000000A3;
         5'd23: r = 34'sh000000051;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [ARENA_BITS-1:0] eff_size(input logic [ARENA_BITS-1:0] s);
      logic [ARENA_BITS-1:0] r;
      r = (int'(s) > MAX_ARENA) ? ARENA_BITS'(MAX_ARENA) : s;
      return r;
   endfunction

endpackage

FILE: sv/ddpu_ctrl.sv
// controller state machine sequencing cordic, multiply and arena reduction
module ddpu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ddpu_pkg::cmd_type   cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RUN  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_WRAP = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [ddpu_pkg::STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in = '0;
               if (req_action == ddpu_pkg::action_load) begin
                  cmd.load_start = 1'b1;
                  state_in       = ST_WRAP;
               end else begin
                  cmd.tick_start = 1'b1;
                  state_in       = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.cordic_en = cnt_ff < ddpu_pkg::CORDIC_END;
            cmd.wrap_en   = cnt_ff <= ddpu_pkg::WRAP_LAST;
            cmd.idx       = cnt_ff;
            if (cnt_ff == ddpu_pkg::RUN_LAST) begin
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            cnt_in   = '0;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.wrap_en = 1'b1;
            cmd.idx     = cnt_ff;
            if (cnt_ff == ddpu_pkg::WRAP_LAST) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/ddpu_dpath.sv
// datapath with settings, pose, cordic, multipliers and arena reduction
module ddpu_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ddpu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ddpu_pkg::CSR_W-1:0]         csr_wdata,
   input  ddpu_pkg::req_type                  req_payload,
   input  ddpu_pkg::cmd_type                  cmd,
   output ddpu_pkg::rsp_type                  rsp_payload
);

   localparam int WW = ddpu_pkg::WRAP_W;
   localparam int CW = ddpu_pkg::CORDIC_W;
   localparam int PB = ddpu_pkg::POS_BITS;

   function automatic logic signed [WW-1:0] wrap_step(
      input logic signed [WW-1:0]        p,
      input logic                        dec,
      input logic                        inc,
      input logic signed [WW-1:0]        wf,
      input logic signed [WW-1:0]        hf,
      input logic [ddpu_pkg::STEP_BITS-1:0] sh,
      input logic                        last
   );
      logic signed [WW-1:0] d;
      logic signed [WW-1:0] r;
      d = last ? wf : (wf <<< sh);
      r = p;
      if (dec && (last || (p - d > hf))) begin
         r = p - d;
      end else if (inc && (last || (p + d < -hf))) begin
         r = p + d;
      end
      return r;
   endfunction

   function automatic logic signed [ddpu_pkg::SPD_BITS:0] clamp(
      input logic signed [ddpu_pkg::SPD_BITS-1:0] v,
      input logic [ddpu_pkg::LIMIT_BITS-1:0]      lim
   );
      logic signed [ddpu_pkg::SPD_BITS:0] vv;
      logic signed [ddpu_pkg::SPD_BITS:0] lv;
      logic signed [ddpu_pkg::SPD_BITS:0] r;
      vv = {v[ddpu_pkg::SPD_BITS-1], v};
      lv = $signed({2'b00, lim});
      if (vv > lv) begin
         r = lv;
      end else if (vv < -lv) begin
         r = -lv;
      end else begin
         r = vv;
      end
      return r;
   endfunction

   // settings
   logic [ddpu_pkg::ARENA_BITS-1:0] width_ff, height_ff;
   logic [ddpu_pkg::GAIN_BITS-1:0]  gain_ff;
   logic [ddpu_pkg::LIMIT_BITS-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ddpu_pkg::WIDTH_RESET;
         height_ff <= ddpu_pkg::HEIGHT_RESET;
         gain_ff   <= ddpu_pkg::GAIN_RESET;
         limit_ff  <= ddpu_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ddpu_pkg::CSR_ARENA_WIDTH:  width_ff  <= csr_wdata[ddpu_pkg::ARENA_BITS-1:0];
            ddpu_pkg::CSR_ARENA_HEIGHT: height_ff <= csr_wdata[ddpu_pkg::ARENA_BITS-1:0];
            ddpu_pkg::CSR_TURN_GAIN:    gain_ff   <= csr_wdata[ddpu_pkg::GAIN_BITS-1:0];
            ddpu_pkg::CSR_SPEED_LIMIT:  limit_ff  <= csr_wdata[ddpu_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // arena bounds in fixed point
   logic [ddpu_pkg::ARENA_BITS-1:0] eff_w, eff_h;
   logic signed [WW-1:0]            wf_x, hf_x, wf_y, hf_y;

   assign eff_w = ddpu_pkg::eff_size(width_ff);
   assign eff_h = ddpu_pkg::eff_size(height_ff);
   assign wf_x  = $signed({{(WW-ddpu_pkg::ARENA_BITS-ddpu_pkg::FRAC_BITS){1'b0}}, eff_w,
                           {ddpu_pkg::FRAC_BITS{1'b0}}});
   assign hf_x  = $signed({{(WW-ddpu_pkg::ARENA_BITS-ddpu_pkg::FRAC_BITS+1){1'b0}},
                           eff_w[ddpu_pkg::ARENA_BITS-1:1], {ddpu_pkg::FRAC_BITS{1'b0}}});
   assign wf_y  = $signed({{(WW-ddpu_pkg::ARENA_BITS-ddpu_pkg::FRAC_BITS){1'b0}}, eff_h,
                           {ddpu_pkg::FRAC_BITS{1'b0}}});
   assign hf_y  = $signed({{(WW-ddpu_pkg::ARENA_BITS-ddpu_pkg::FRAC_BITS+1){1'b0}},
                           eff_h[ddpu_pkg::ARENA_BITS-1:1], {ddpu_pkg::FRAC_BITS{1'b0}}});

   // registers
   logic signed [PB-1:0]                    pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [ddpu_pkg::ANG_BITS-1:0]           pose_hd_ff, pose_hd_in;
   logic signed [ddpu_pkg::SPD_BITS:0]      lspd_ff, lspd_in, rspd_ff, rspd_in;
   logic signed [CW-1:0]                    cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [WW-1:0]                    wx_ff, wx_in, wy_ff, wy_in;
   logic                                    decx_ff, decx_in, incx_ff, incx_in;
   logic                                    decy_ff, decy_in, incy_ff, incy_in;
   logic signed [ddpu_pkg::PROD_W-1:0]      px_ff, px_in, py_ff, py_in;
   logic signed [ddpu_pkg::DPROD_W-1:0]     ph_ff, ph_in;
   ddpu_pkg::rsp_type                       rsp_ff, rsp_in;

   // combinational helpers
   logic signed [CW-1:0]                    z0, xs, ys, atan_i;
   logic signed [WW-1:0]                    srcx, srcy, basex, basey;
   logic signed [ddpu_pkg::SUM_W-1:0]       spd_sum, spd_diff;
   logic signed [ddpu_pkg::PROD_W-1:0]      rndx, rndy;
   logic signed [ddpu_pkg::DPROD_W-1:0]     rndh;
   logic signed [ddpu_pkg::DX_W-1:0]        dx, dy;
   logic [ddpu_pkg::STEP_BITS-1:0]          wshift;
   logic                                    wlast, wload;

   assign z0 = $signed({{(CW-32){pose_hd_ff[ddpu_pkg::ANG_BITS-1]}}, pose_hd_ff,
                        {ddpu_pkg::ANG_SHIFT{1'b0}}});
   assign xs      = cx_ff >>> cmd.idx;
   assign ys      = cy_ff >>> cmd.idx;
   assign atan_i  = ddpu_pkg::atan_entry(cmd.idx);
   assign wshift  = ddpu_pkg::WRAP_TOPV - cmd.idx;
   assign wlast   = cmd.idx == ddpu_pkg::WRAP_LAST;
   assign wload   = cmd.tick_start || cmd.load_start || cmd.add;

   assign spd_sum  = {lspd_ff[ddpu_pkg::SPD_BITS], lspd_ff}
                   + {rspd_ff[ddpu_pkg::SPD_BITS], rspd_ff};
   assign spd_diff = {lspd_ff[ddpu_pkg::SPD_BITS], lspd_ff}
                   - {rspd_ff[ddpu_pkg::SPD_BITS], rspd_ff};

   assign rndx = px_ff + $signed({{(ddpu_pkg::PROD_W-31){1'b0}}, 1'b1, 30'd0});
   assign rndy = py_ff + $signed({{(ddpu_pkg::PROD_W-31){1'b0}}, 1'b1, 30'd0});
   assign rndh = ph_ff + $signed({{(ddpu_pkg::DPROD_W-ddpu_pkg::FRAC_BITS){1'b0}}, 1'b1,
                                  {(ddpu_pkg::FRAC_BITS-1){1'b0}}});
   assign dx   = rndx[ddpu_pkg::PROD_W-1:31];
   assign dy   = rndy[ddpu_pkg::PROD_W-1:31];

   assign basex = $signed({{(WW-PB){wx_ff[PB-1]}}, wx_ff[PB-1:0]});
   assign basey = $signed({{(WW-PB){wy_ff[PB-1]}}, wy_ff[PB-1:0]});

   always_comb begin
      srcx = basex + $signed({{(WW-ddpu_pkg::DX_W){dx[ddpu_pkg::DX_W-1]}}, dx});
      srcy = basey + $signed({{(WW-ddpu_pkg::DX_W){dy[ddpu_pkg::DX_W-1]}}, dy});
      if (cmd.load_start) begin
         srcx = $signed({{(WW-PB){req_payload.new_x[PB-1]}}, req_payload.new_x});
         srcy = $signed({{(WW-PB){req_payload.new_y[PB-1]}}, req_payload.new_y});
      end else if (cmd.tick_start) begin
         srcx = $signed({{(WW-PB){pose_x_ff[PB-1]}}, pose_x_ff});
         srcy = $signed({{(WW-PB){pose_y_ff[PB-1]}}, pose_y_ff});
      end
   end

   always_comb begin
      pose_x_in  = pose_x_ff;
      pose_y_in  = pose_y_ff;
      pose_hd_in = pose_hd_ff;
      lspd_in    = lspd_ff;
      rspd_in    = rspd_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      wx_in      = wx_ff;
      wy_in      = wy_ff;
      decx_in    = decx_ff;
      incx_in    = incx_ff;
      decy_in    = decy_ff;
      incy_in    = incy_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      ph_in      = ph_ff;
      rsp_in     = rsp_ff;

      if (cmd.tick_start) begin
         lspd_in = clamp(req_payload.left_speed, limit_ff);
         rspd_in = clamp(req_payload.right_speed, limit_ff);
         if (z0 > ddpu_pkg::QUARTER) begin
            cx_in = '0;
            cy_in = ddpu_pkg::CORDIC_GAIN;
            cz_in = z0 - ddpu_pkg::QUARTER;
         end else if (z0 < -ddpu_pkg::QUARTER) begin
            cx_in = '0;
            cy_in = -ddpu_pkg::CORDIC_GAIN;
            cz_in = z0 + ddpu_pkg::QUARTER;
         end else begin
            cx_in = ddpu_pkg::CORDIC_GAIN;
            cy_in = '0;
            cz_in = z0;
         end
      end

      if (cmd.load_start) begin
         pose_hd_in = req_payload.new_heading;
      end

      if (cmd.cordic_en) begin
         if (!cz_ff[CW-1]) begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - atan_i;
         end else begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + atan_i;
         end
      end

      if (wload) begin
         wx_in   = srcx;
         wy_in   = srcy;
         decx_in = (eff_w != '0) && (srcx > hf_x);
         incx_in = (eff_w != '0) && (srcx < -hf_x);
         decy_in = (eff_h != '0) && (srcy > hf_y);
         incy_in = (eff_h != '0) && (srcy < -hf_y);
      end else if (cmd.wrap_en) begin
         wx_in = wrap_step(wx_ff, decx_ff, incx_ff, wf_x, hf_x, wshift, wlast);
         wy_in = wrap_step(wy_ff, decy_ff, incy_ff, wf_y, hf_y, wshift, wlast);
      end

      if (cmd.mul) begin
         px_in = spd_sum * $signed(cy_ff[ddpu_pkg::TRIG_W-1:0]);
         py_in = spd_sum * $signed(cx_ff[ddpu_pkg::TRIG_W-1:0]);
         ph_in = spd_diff * $signed({1'b0, gain_ff});
      end

      if (cmd.add) begin
         pose_hd_in = pose_hd_ff + rndh[ddpu_pkg::FRAC_BITS +: ddpu_pkg::ANG_BITS];
      end

      if (cmd.commit) begin
         pose_x_in         = wx_ff[PB-1:0];
         pose_y_in         = wy_ff[PB-1:0];
         rsp_in.x_position = wx_ff[PB-1:0];
         rsp_in.y_position = wy_ff[PB-1:0];
         rsp_in.heading    = pose_hd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         pose_hd_ff <= '0;
      end else begin
         pose_x_ff  <= pose_x_in;
         pose_y_ff  <= pose_y_in;
         pose_hd_ff <= pose_hd_in;
      end
   end

   always_ff @(posedge clock) begin
      lspd_ff <= lspd_in;
      rspd_ff <= rspd_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      decx_ff <= decx_in;
      incx_ff <= incx_in;
      decy_ff <= decy_in;
      incy_ff <= incy_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      ph_ff   <= ph_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: sv/differential_drive_pose_update_top.sv
// top level of the differential drive pose update block
// Keeps a robot pose (x, y in Q12.8 pixels, heading as a 16-bit binary angle) on a torus
// sized by the arena settings. A tick beat clamps both wheel speeds, moves the pose along
// the current heading with a 16-iteration CORDIC sine and cosine and turns it by the
// speed difference times the turn gain; a load beat sets the pose. Every request beat
// yields one response beat with the new pose. One beat is in flight at a time: a tick
// takes the beat, runs the CORDIC iterations while the stored pose is reduced, then
// does a multiply step, an add step, the bit-serial arena reduction and the hand-off
// of the result; a load takes the beat, runs the reduction and hands off the result.
// The hand-off waits while the previous response is still stalled. The result register
// lets the next request be taken while a response is still stalled.
`include "assert_macros.svh"

module differential_drive_pose_update_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ddpu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ddpu_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ddpu_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ddpu_pkg::rsp_type               rsp_payload
);

   ddpu_pkg::cmd_type cmd;

   ddpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   ddpu_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "no busy after accept")
   `ASSERT_NEXT(a_mul_then_add, cmd.mul, cmd.add, "multiply not followed by pose add")
   `ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid, "committed pose not presented")
   `ASSERT_ALWAYS(a_one_start, !(cmd.tick_start && cmd.load_start), "tick and load overlap")
   `ASSERT_ALWAYS(a_commit_busy, !(cmd.commit && !req_stall), "commit while idle")

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the differential drive pose update block: pose prediction and checks
`timescale 1ns / 100ps

import ddpu_pkg::*;

class pose_scoreboard;
   int unsigned         arena_w;
   int unsigned         arena_h;
   int unsigned         gain;
   int unsigned         limit;
   longint              pos_x;
   longint              pos_y;
   logic [ANG_BITS-1:0] hd;
   longint              atan_q30[24];
   rsp_type             expected_poses[$];
   int                  errors;

   function new();
      atan_q30 = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
         64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
         64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      arena_w = int'(WIDTH_RESET);
      arena_h = int'(HEIGHT_RESET);
      gain    = int'(GAIN_RESET);
      limit   = int'(LIMIT_RESET);
      pos_x   = 0;
      pos_y   = 0;
      hd      = '0;
      errors  = 0;
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      case (idx)
         CSR_ARENA_WIDTH:  arena_w = val % (1 << ARENA_BITS);
         CSR_ARENA_HEIGHT: arena_h = val % (1 << ARENA_BITS);
         CSR_TURN_GAIN:    gain    = val % (1 << GAIN_BITS);
         CSR_SPEED_LIMIT:  limit   = val % (1 << LIMIT_BITS);
         default: ;
      endcase
   endfunction

   // torus reduction of one axis, then kept in 20 bits
   function longint fold(longint p, int unsigned size);
      longint                     eff;
      longint                     wf;
      longint                     hf;
      logic signed [POS_BITS-1:0] t;
      eff = (size > MAX_ARENA) ? longint'(MAX_ARENA) : longint'(size);
      if (eff != 0) begin
         wf = eff << FRAC_BITS;
         hf = (eff / 2) << FRAC_BITS;
         if (p > hf) begin
            p = p - ((p - hf + wf - 1) / wf) * wf;
         end else if (p < -hf) begin
            p = p + ((-hf - p + wf - 1) / wf) * wf;
         end
      end
      t = p[POS_BITS-1:0];
      return longint'(t);
   endfunction

   function void fold_pose();
      pos_x = fold(pos_x, arena_w);
      pos_y = fold(pos_y, arena_h);
   endfunction

   function longint clamp(longint v);
      longint lim;
      lim = longint'(limit);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function longint round_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function void cordic(input logic [ANG_BITS-1:0] ang, output longint sn, output longint cs);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      int     i;
      z = longint'($signed(ang)) * 65536;
      if (z > (longint'(1) << 30)) begin
         x = 0;
         y = longint'(CORDIC_GAIN);
         z = z - (longint'(1) << 30);
      end else if (z < -(longint'(1) << 30)) begin
         x = 0;
         y = -longint'(CORDIC_GAIN);
         z = z + (longint'(1) << 30);
      end else begin
         x = longint'(CORDIC_GAIN);
         y = 0;
      end
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_q30[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_q30[i];
         end
      end
      sn = y;
      cs = x;
   endfunction

   function void note_request(req_type r);
      longint  l;
      longint  rr;
      longint  s;
      longint  sn;
      longint  cs;
      longint  dh;
      rsp_type e;
      if (r.action == action_load) begin
         pos_x = longint'($signed(r.new_x));
         pos_y = longint'($signed(r.new_y));
         hd    = r.new_heading;
         fold_pose();
      end else begin
         l  = clamp(longint'($signed(r.left_speed)));
         rr = clamp(longint'($signed(r.right_speed)));
         s  = l + rr;
         fold_pose();
         cordic(hd, sn, cs);
         pos_x = pos_x + round_shr(s * sn, 31);
         pos_y = pos_y + round_shr(s * cs, 31);
         dh    = round_shr((l - rr) * longint'(gain), FRAC_BITS);
         hd    = hd + dh[ANG_BITS-1:0];
         fold_pose();
      end
      e.x_position = pos_x[POS_BITS-1:0];
      e.y_position = pos_y[POS_BITS-1:0];
      e.heading    = hd;
      expected_poses.push_back(e);
   endfunction

   task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_pose(rsp_type got);
      rsp_type e;
      if (expected_poses.size() == 0) begin
         report($sformatf("pose beat with nothing pending: x %0d y %0d heading %0d",
                          got.x_position, got.y_position, got.heading));
      end else begin
         e = expected_poses.pop_front();
         if (got.x_position !== e.x_position)
            report($sformatf("x_position got %0d want %0d", got.x_position, e.x_position));
         if (got.y_position !== e.y_position)
            report($sformatf("y_position got %0d want %0d", got.y_position, e.y_position));
         if (got.heading !== e.heading)
            report($sformatf("heading got %0d want %0d", got.heading, e.heading));
      end
   endtask

   function int pending();
      return expected_poses.size();
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int SETTLE         = 40;
   localparam int RAND_PER_PHASE = 230;
   localparam int HOLD_LEN       = 400;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index   = '0;
   logic [CSR_W-1:0]       csr_wdata   = '0;
   logic                   req_valid   = 1'b0;
   req_type                req_payload = '0;
   logic                   rsp_stall   = 1'b0;
   logic                   req_stall;
   logic                   rsp_valid;
   rsp_type                rsp_payload;

   pose_scoreboard sb;
   int             cycles;
   bit             stall_on    = 1'b0;
   bit             gaps_on     = 1'b0;
   int             hold_cycles = 0;
   int             burst_left  = 0;

   differential_drive_pose_update_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // receiver side: random stall bursts, and a long hold-off whenever one is set
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left = burst_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 9) < 2) begin
         burst_left = int'($urandom_range(1, 8)) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pose(rsp_payload);
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [SPD_BITS-1:0] pick_speed(int lim);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = int'($urandom_range(0, 2 * lim)) - lim;
         5, 6: v = int'($urandom);
         7: begin
            case ($urandom_range(0, 5))
               0: v = 32767;
               1: v = -32768;
               2: v = lim;
               3: v = -lim;
               4: v = lim + 1;
               default: v = -lim - 1;
            endcase
         end
         default: v = int'($urandom_range(0, 512)) - 256;
      endcase
      return SPD_BITS'(v);
   endfunction

   // either any 20-bit value or one close to an arena edge
   function automatic logic signed [POS_BITS-1:0] pick_pos(int unsigned size);
      int eff;
      int half;
      int v;
      eff = (size > MAX_ARENA) ? MAX_ARENA : int'(size);
      if (eff == 0 || $urandom_range(0, 1) == 0) begin
         v = int'($urandom);
      end else begin
         half = (eff / 2) << FRAC_BITS;
         v = (($urandom_range(0, 1) == 1) ? half : -half) + int'($urandom_range(0, 600)) - 300;
      end
      return POS_BITS'(v);
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int      lim;
      lim = int'(sb.limit);
      r.action      = ($urandom_range(0, 99) < 12) ? action_load : action_tick;
      r.left_speed  = pick_speed(lim);
      r.right_speed = ($urandom_range(0, 4) == 0) ? r.left_speed : pick_speed(lim);
      r.new_x       = pick_pos(sb.arena_w);
      r.new_y       = pick_pos(sb.arena_h);
      r.new_heading = ANG_BITS'($urandom);
      return r;
   endfunction

   function automatic req_type mk_tick(int l, int r);
      req_type q;
      q.action      = action_tick;
      q.left_speed  = SPD_BITS'(l);
      q.right_speed = SPD_BITS'(r);
      q.new_x       = POS_BITS'($urandom);
      q.new_y       = POS_BITS'($urandom);
      q.new_heading = ANG_BITS'($urandom);
      return q;
   endfunction

   function automatic req_type mk_load(int x, int y, int h);
      req_type q;
      q.action      = action_load;
      q.left_speed  = SPD_BITS'($urandom);
      q.right_speed = SPD_BITS'($urandom);
      q.new_x       = POS_BITS'(x);
      q.new_y       = POS_BITS'(y);
      q.new_heading = ANG_BITS'(h);
      return q;
   endfunction

   task automatic send_req(input req_type r);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 3) == 0) gap = int'($urandom_range(1, 8));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned g;
      int unsigned l;
      int          p;
      int          n;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      stall_on = 1'b1;
      gaps_on  = 1'b1;

      // directed beats at the reset settings
      send_req(mk_tick(0, 0));
      send_req(mk_tick(32767, 32767));
      send_req(mk_tick(-32768, -32768));
      send_req(mk_tick(-32768, 32767));
      send_req(mk_tick(32767, -32768));
      send_req(mk_tick(2561, -2561));
      send_req(mk_load(524287, -524288, -32768));
      send_req(mk_tick(1000, 1000));
      send_req(mk_load(81920, -61440, 32767));
      send_req(mk_load(81921, -61441, 16384));
      send_req(mk_tick(2560, 2560));
      send_req(mk_load(0, 0, 16385));
      send_req(mk_tick(2560, 2560));
      send_req(mk_load(0, 0, -16384));
      send_req(mk_tick(-2560, 2560));
      send_req(mk_load(0, 0, -16385));
      send_req(mk_tick(1, -1));
      send_req(mk_load(-81920, 61440, -32768));
      send_req(mk_tick(2560, 2560));
      send_req(mk_load(-81921, 0, 0));
      send_req(mk_tick(-128, -127));

      for (p = 1; p <= 7; p++) begin
         drain();
         case (p)
            1: begin w = 4096; h = 4096; g = 4095; l = 32767; end
            2: begin w = 16; h = 16; g = 0; l = 0; end
            3: begin w = 0; h = 0; g = 209; l = 2560; end
            4: begin w = 8191; h = 5000; g = 1000; l = 5000; end
            5: begin
               w = 17;
               h = 4095;
               g = $urandom_range(0, 4095);
               l = $urandom_range(0, 32767);
            end
            6: begin
               w = $urandom_range(16, 4096);
               h = $urandom_range(16, 4096);
               g = $urandom_range(0, 4095);
               l = $urandom_range(0, 4000);
            end
            default: begin
               w = int'(WIDTH_RESET);
               h = int'(HEIGHT_RESET);
               g = int'(GAIN_RESET);
               l = int'(LIMIT_RESET);
            end
         endcase
         write_reg(CSR_ARENA_WIDTH, w);
         write_reg(CSR_ARENA_HEIGHT, h);
         write_reg(CSR_TURN_GAIN, g);
         write_reg(CSR_SPEED_LIMIT, l);

         if (p == 1) begin
            // full-size arena edge
            send_req(mk_load(524287 - 2560, 0, 16384));
            send_req(mk_tick(1280, 1280));
            send_req(mk_tick(1280, 1280));
            send_req(mk_load(-524288, -524288, 0));
            send_req(mk_tick(0, 0));
         end
         if (p == 2) begin
            // receiver holds off while beats keep coming
            gaps_on = 1'b0;
            hold_cycles = HOLD_LEN;
            for (n = 0; n < 40; n++) send_req(rand_req());
            gaps_on = 1'b1;
         end
         if (p == 7) begin
            stall_on = 1'b0;
            gaps_on  = 1'b0;
         end
         for (n = 0; n < RAND_PER_PHASE; n++) begin
            if (p == 5 && n == RAND_PER_PHASE / 2) drain();
            send_req(rand_req());
         end
      end

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
